>>> rtl/core/ultrasonic_range_controller_macros.svh
// Assertion helpers for the ranger checker
`ifndef ULTRASONIC_RANGE_CONTROLLER_MACROS_SVH
`define ULTRASONIC_RANGE_CONTROLLER_MACROS_SVH

// same-cycle implication
`define URC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urc assertion failed");

// next-cycle implication
`define URC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urc assertion failed");

`endif

>>> rtl/core/urc_pkg.sv
package urc_pkg;

  localparam int unsigned BAR_CELLS_DEF   = 20;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned DIST_W   = 14;
  localparam int unsigned PCNT_W   = 16;
  localparam int unsigned MAXD_W   = 10;
  localparam int unsigned TRIG_W   = 8;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BAR_W    = 5;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned UPC_W    = 4;
  localparam int unsigned DIV_W    = 14;
  localparam int unsigned DIV_STEPS = DIV_W;

  localparam logic [DIST_W-1:0]  DIST_MAX       = '1;
  localparam logic [MAXD_W-1:0]  MAX_DIST_RST   = 10'd300;
  localparam logic [MAXD_W-1:0]  MIN_DIST_RST   = 10'd5;
  localparam logic [TRIG_W-1:0]  TRIG_RST       = 8'd3;
  localparam logic [PCNT_W-1:0]  BLANK_RST      = 16'd750;
  localparam logic [PCNT_W-1:0]  LISTEN_RST     = 16'd1000;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 16'd15224;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TRIG, PH_BLANK, PH_LISTEN, PH_MEASURE
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_IN_RANGE, ST_OUT_RANGE, ST_NO_ECHO
  } status_e;

  typedef enum logic [2:0] {
    REG_MAX_DIST, REG_MIN_DIST, REG_TRIG, REG_BLANK, REG_LISTEN, REG_SCALE
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_FETCH, OP_TICK, OP_MUL, OP_SAT, OP_RANGE,
    OP_DIV_STEP_LD, OP_DIV_CELLS_LD, OP_DIV_STEP, OP_BAR, OP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    CC_NEVER, CC_ALWAYS, CC_NO_XACT, CC_NO_CALC, CC_OUT_RANGE, CC_DIV_RUN, CC_OUT_BUSY
  } cond_e;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UA_FETCH  = 4'd0;
  localparam upc_t UA_TICK   = 4'd1;
  localparam upc_t UA_MUL    = 4'd2;
  localparam upc_t UA_SAT    = 4'd3;
  localparam upc_t UA_RANGE  = 4'd4;
  localparam upc_t UA_DIVA   = 4'd5;
  localparam upc_t UA_DIVA_S = 4'd6;
  localparam upc_t UA_DIVB   = 4'd7;
  localparam upc_t UA_DIVB_S = 4'd8;
  localparam upc_t UA_BAR    = 4'd9;
  localparam upc_t UA_EMIT   = 4'd10;
  localparam upc_t UA_NOP    = 4'd11;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    upc_t  target;
  } uword_t;

  // taken jump when cond is true, else fall through to the next step
  function automatic uword_t ucode_rom(input upc_t addr);
    uword_t w;
    case (addr)
      UA_FETCH:  w = '{OP_FETCH,        CC_NO_XACT,   UA_FETCH};
      UA_TICK:   w = '{OP_TICK,         CC_NO_CALC,   UA_EMIT};
      UA_MUL:    w = '{OP_MUL,          CC_NEVER,     UA_FETCH};
      UA_SAT:    w = '{OP_SAT,          CC_NEVER,     UA_FETCH};
      UA_RANGE:  w = '{OP_RANGE,        CC_OUT_RANGE, UA_EMIT};
      UA_DIVA:   w = '{OP_DIV_STEP_LD,  CC_NEVER,     UA_FETCH};
      UA_DIVA_S: w = '{OP_DIV_STEP,     CC_DIV_RUN,   UA_DIVA_S};
      UA_DIVB:   w = '{OP_DIV_CELLS_LD, CC_NEVER,     UA_FETCH};
      UA_DIVB_S: w = '{OP_DIV_STEP,     CC_DIV_RUN,   UA_DIVB_S};
      UA_BAR:    w = '{OP_BAR,          CC_NEVER,     UA_FETCH};
      UA_EMIT:   w = '{OP_EMIT,         CC_OUT_BUSY,  UA_EMIT};
      UA_NOP:    w = '{OP_NOP,          CC_ALWAYS,    UA_FETCH};
      default:   w = '{OP_NOP,          CC_ALWAYS,    UA_FETCH};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/ultrasonic_range_controller.sv
// Single-pin ultrasonic ranger. Each input transaction is one microsecond
// tick (start request and sampled echo level) and yields exactly one result
// transaction with pin drive, busy, done, status, held distance and bar
// length. A microcode ROM of twelve steps runs the datapath. A tick runs
// fetch, phase update, emit and return; a tick that ends a measurement runs
// width-times-scale multiply, saturate and range check before emit, and if
// in range two 14-step passes through one shared restoring divider (bar
// step from the maximum, then the cell count) and the bar length. Stalls on
// the result side hold the sequencer at the emit step; the next tick is taken
// while a result waits in the output register.
module ultrasonic_range_controller
  import urc_pkg::*;
#(
  parameter int unsigned BAR_CELLS   = BAR_CELLS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                start_req_i,
  input  logic                echo_level_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                pin_drive_enable_o,
  output logic                pin_drive_level_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [DIST_W-1:0]   range_cm_o,
  output logic [BAR_W-1:0]    bar_cells_o
);

  localparam int unsigned PROD_W = COUNT_WIDTH + SCALE_W;
  localparam int unsigned HI_W   = (COUNT_WIDTH > DIST_W) ? COUNT_WIDTH : DIST_W;
  localparam int unsigned DCNT_W = $clog2(DIV_STEPS);
  localparam logic [COUNT_WIDTH-1:0] WIDTH_MAX = '1;
  localparam logic [DIV_W-1:0]       BAR_N     = DIV_W'(BAR_CELLS);
  localparam logic [DCNT_W-1:0]      DCNT_LAST = DCNT_W'(DIV_STEPS - 1);

  // configuration
  logic [MAXD_W-1:0]  max_dist_q, min_dist_q;
  logic [TRIG_W-1:0]  trig_q;
  logic [PCNT_W-1:0]  blank_q, listen_q;
  logic [SCALE_W-1:0] scale_q;
  logic               cfg_we;
  logic [2:0]         cfg_idx;

  // sequencer
  upc_t   upc_q, upc_d;
  uword_t uw;
  logic   cond_true, in_xact, out_free, calc_needed, range_ok, div_run, no_echo_end;

  // tick state
  phase_e                 phase_q, phase_d;
  logic [PCNT_W-1:0]      pcnt_q, pcnt_d, pcnt_inc;
  logic [COUNT_WIDTH-1:0] wcnt_q, wcnt_d;
  logic [DIST_W-1:0]      last_dist_q, last_dist_d;
  logic [TRIG_W-1:0]      trig_lim;
  logic [PCNT_W-1:0]      listen_lim;

  // datapath
  logic                start_q, start_d, echo_q, echo_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [HI_W-1:0]     prod_hi;
  logic [DIV_W-1:0]    rem_q, rem_d, quo_q, quo_d, dvsr_q, dvsr_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [DIV_W:0]      rem_sh, rem_sub;
  logic                div_fits;
  logic                res_drive_q, res_drive_d, res_done_q, res_done_d;
  status_e             res_status_q, res_status_d;
  logic [BAR_W-1:0]    res_bar_q, res_bar_d;

  // output register
  logic                out_valid_q, out_valid_d, out_load;
  logic                out_drive_q, out_busy_q, out_done_q;
  status_e             out_status_q;
  logic [DIST_W-1:0]   out_dist_q;
  logic [BAR_W-1:0]    out_bar_q;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MAX_DIST_RST;
      min_dist_q <= MIN_DIST_RST;
      trig_q     <= TRIG_RST;
      blank_q    <= BLANK_RST;
      listen_q   <= LISTEN_RST;
      scale_q    <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MAX_DIST: max_dist_q <= pwdata[MAXD_W-1:0];
        REG_MIN_DIST: min_dist_q <= pwdata[MAXD_W-1:0];
        REG_TRIG:     trig_q     <= pwdata[TRIG_W-1:0];
        REG_BLANK:    blank_q    <= pwdata[PCNT_W-1:0];
        REG_LISTEN:   listen_q   <= pwdata[PCNT_W-1:0];
        REG_SCALE:    scale_q    <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MAX_DIST: prdata = PDATA_W'(max_dist_q);
      REG_MIN_DIST: prdata = PDATA_W'(min_dist_q);
      REG_TRIG:     prdata = PDATA_W'(trig_q);
      REG_BLANK:    prdata = PDATA_W'(blank_q);
      REG_LISTEN:   prdata = PDATA_W'(listen_q);
      REG_SCALE:    prdata = PDATA_W'(scale_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign uw          = ucode_rom(upc_q);
  assign in_ready_o  = (uw.op == OP_FETCH);
  assign in_xact     = in_valid_i & in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign calc_needed = (phase_q == PH_MEASURE) && !echo_q;
  assign div_run     = (dcnt_q != DCNT_LAST);
  assign range_ok    = (last_dist_q >= DIST_W'(min_dist_q)) &&
                       (last_dist_q <= DIST_W'(max_dist_q));

  always_comb begin
    case (uw.cond)
      CC_NEVER:     cond_true = 1'b0;
      CC_ALWAYS:    cond_true = 1'b1;
      CC_NO_XACT:   cond_true = !in_xact;
      CC_NO_CALC:   cond_true = !calc_needed;
      CC_OUT_RANGE: cond_true = !range_ok;
      CC_DIV_RUN:   cond_true = div_run;
      CC_OUT_BUSY:  cond_true = !out_free;
      default:      cond_true = 1'b0;
    endcase
    upc_d = cond_true ? uw.target : upc_q + 1'b1;
  end

  // ---------------- tick state: next state ----------------
  assign pcnt_inc    = pcnt_q + 1'b1;
  assign trig_lim    = (trig_q == '0) ? TRIG_W'(1) : trig_q;
  assign listen_lim  = (listen_q == '0) ? PCNT_W'(1) : listen_q;
  assign no_echo_end = (phase_q == PH_LISTEN) && !echo_q && (pcnt_inc >= listen_lim);

  always_comb begin
    phase_d = phase_q;
    pcnt_d  = pcnt_q;
    wcnt_d  = wcnt_q;
    if (uw.op == OP_TICK) begin
      case (phase_q)
        PH_TRIG: begin
          if (pcnt_inc >= PCNT_W'(trig_lim)) begin
            pcnt_d  = '0;
            phase_d = (blank_q == '0) ? PH_LISTEN : PH_BLANK;
          end else begin
            pcnt_d = pcnt_inc;
          end
        end
        PH_BLANK: begin
          if (pcnt_inc >= blank_q) begin
            pcnt_d  = '0;
            phase_d = PH_LISTEN;
          end else begin
            pcnt_d = pcnt_inc;
          end
        end
        PH_LISTEN: begin
          if (echo_q) begin
            wcnt_d  = COUNT_WIDTH'(1);
            pcnt_d  = '0;
            phase_d = PH_MEASURE;
          end else if (no_echo_end) begin
            pcnt_d  = '0;
            phase_d = PH_IDLE;
          end else begin
            pcnt_d = pcnt_inc;
          end
        end
        PH_MEASURE: begin
          if (echo_q) begin
            if (wcnt_q != WIDTH_MAX) begin
              wcnt_d = wcnt_q + 1'b1;
            end
          end else begin
            pcnt_d  = '0;
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (start_q) begin
            pcnt_d  = '0;
            wcnt_d  = '0;
            phase_d = PH_TRIG;
          end
        end
      endcase
    end
  end

  // ---------------- datapath and results ----------------
  assign prod_hi  = HI_W'(prod_q >> FRAC_W);
  assign rem_sh   = {rem_q, quo_q[DIV_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvsr_q};
  assign div_fits = (rem_sh >= {1'b0, dvsr_q});

  always_comb begin
    start_d      = start_q;
    echo_d       = echo_q;
    prod_d       = prod_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    dvsr_d       = dvsr_q;
    dcnt_d       = dcnt_q;
    last_dist_d  = last_dist_q;
    res_drive_d  = res_drive_q;
    res_done_d   = res_done_q;
    res_status_d = res_status_q;
    res_bar_d    = res_bar_q;
    case (uw.op)
      OP_FETCH: begin
        if (in_xact) begin
          start_d = start_req_i;
          echo_d  = echo_level_i;
        end
      end
      OP_TICK: begin
        res_drive_d  = (phase_q == PH_TRIG);
        res_done_d   = calc_needed;
        res_status_d = ST_IN_RANGE;
        res_bar_d    = '0;
        if (no_echo_end) begin
          res_done_d   = 1'b1;
          res_status_d = ST_NO_ECHO;
          last_dist_d  = '0;
        end
      end
      OP_MUL: prod_d = PROD_W'(wcnt_q) * PROD_W'(scale_q);
      OP_SAT: last_dist_d = (prod_hi > HI_W'(DIST_MAX)) ? DIST_MAX : prod_hi[DIST_W-1:0];
      OP_RANGE: res_status_d = range_ok ? ST_IN_RANGE : ST_OUT_RANGE;
      OP_DIV_STEP_LD: begin
        quo_d  = DIV_W'(max_dist_q);
        rem_d  = '0;
        dvsr_d = BAR_N;
        dcnt_d = '0;
      end
      OP_DIV_CELLS_LD: begin
        quo_d  = DIV_W'(last_dist_q);
        rem_d  = '0;
        dvsr_d = (quo_q == '0) ? DIV_W'(1) : quo_q;
        dcnt_d = '0;
      end
      OP_DIV_STEP: begin
        rem_d  = div_fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        quo_d  = {quo_q[DIV_W-2:0], div_fits};
        dcnt_d = dcnt_q + 1'b1;
      end
      OP_BAR: res_bar_d = (quo_q >= BAR_N) ? '0 : BAR_W'(BAR_N - quo_q);
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  assign out_load = (uw.op == OP_EMIT) && out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UA_FETCH;
      phase_q     <= PH_IDLE;
      pcnt_q      <= '0;
      wcnt_q      <= '0;
      last_dist_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      phase_q     <= phase_d;
      pcnt_q      <= pcnt_d;
      wcnt_q      <= wcnt_d;
      last_dist_q <= last_dist_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q      <= start_d;
    echo_q       <= echo_d;
    prod_q       <= prod_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    dvsr_q       <= dvsr_d;
    dcnt_q       <= dcnt_d;
    res_drive_q  <= res_drive_d;
    res_done_q   <= res_done_d;
    res_status_q <= res_status_d;
    res_bar_q    <= res_bar_d;
    if (out_load) begin
      out_drive_q  <= res_drive_q;
      out_busy_q   <= (phase_q != PH_IDLE);
      out_done_q   <= res_done_q;
      out_status_q <= res_status_q;
      out_dist_q   <= last_dist_q;
      out_bar_q    <= res_bar_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pin_drive_enable_o = out_drive_q;
  assign pin_drive_level_o  = out_drive_q;
  assign busy_res_o         = out_busy_q;
  assign done_res_o         = out_done_q;
  assign status_o           = out_status_q;
  assign range_cm_o         = out_dist_q;
  assign bar_cells_o        = out_bar_q;

endmodule

>>> rtl/core/urc_checker.sv
`include "ultrasonic_range_controller_macros.svh"

module urc_checker
  import urc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                busy_res_o,
  input logic                done_res_o,
  input logic [STATUS_W-1:0] status_o,
  input logic [DIST_W-1:0]   range_cm_o,
  input logic [BAR_W-1:0]    bar_cells_o
);

  `URC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(range_cm_o) && $stable(status_o) && $stable(done_res_o))
  `URC_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, out_valid_o && done_res_o, !busy_res_o)
  `URC_ASSERT_IMPL(a_status_on_done, clk_i, rst_ni, out_valid_o && !done_res_o, status_o == ST_IN_RANGE && bar_cells_o == '0)
  `URC_ASSERT_IMPL(a_bar_in_range, clk_i, rst_ni, out_valid_o && bar_cells_o != '0, done_res_o && status_o == ST_IN_RANGE)
  `URC_ASSERT_IMPL(a_no_echo_zero, clk_i, rst_ni, out_valid_o && done_res_o && status_o == ST_NO_ECHO, range_cm_o == '0)

endmodule

bind ultrasonic_range_controller urc_checker u_urc_checker (.*);

>>> tb/sv/urc_tick_checker.sv
`timescale 1ns / 1ps

module urc_tick_checker
  import urc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [PADDR_W-1:0]  paddr_i,
  input  logic [PDATA_W-1:0]  pwdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                start_req_i,
  input  logic                echo_level_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                pin_drive_enable_i,
  input  logic                pin_drive_level_i,
  input  logic                busy_res_i,
  input  logic                done_res_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [DIST_W-1:0]   range_cm_i,
  input  logic [BAR_W-1:0]    bar_cells_i,
  output int unsigned         pending_o,
  output int unsigned         mismatches_o
);

  typedef struct packed {
    logic              drive_en;
    logic              drive_lvl;
    logic              busy;
    logic              done;
    status_e           status;
    logic [DIST_W-1:0] range_cm;
    logic [BAR_W-1:0]  bar;
  } tick_result_t;

  localparam int unsigned WIDTH_SAT = 32'((64'd1 << COUNT_WIDTH_DEF) - 1);

  int unsigned cfg_max, cfg_min, cfg_trig, cfg_blank, cfg_listen, cfg_scale;
  phase_e            ph;
  int unsigned       ph_cnt;
  int unsigned       width_cnt;
  logic [DIST_W-1:0] last_dist;

  tick_result_t expected_ticks[$];
  tick_result_t want, got;
  int unsigned  tick_depth;
  int unsigned  mismatch_cnt;

  assign pending_o    = tick_depth;
  assign mismatches_o = mismatch_cnt;

  task automatic step_ranger(input logic start, input logic echo, output tick_result_t r);
    int unsigned       lim;
    int unsigned       bar_step;
    int unsigned       cells;
    longint unsigned   prod;
    logic [DIST_W-1:0] d;
    r = '0;
    r.status = ST_IN_RANGE;
    case (ph)
      PH_TRIG: begin
        r.drive_en  = 1'b1;
        r.drive_lvl = 1'b1;
        lim = (cfg_trig == 0) ? 1 : cfg_trig;
        ph_cnt++;
        if (ph_cnt >= lim) begin
          ph_cnt = 0;
          ph = (cfg_blank == 0) ? PH_LISTEN : PH_BLANK;
        end
      end
      PH_BLANK: begin
        ph_cnt++;
        if (ph_cnt >= cfg_blank) begin
          ph_cnt = 0;
          ph = PH_LISTEN;
        end
      end
      PH_LISTEN: begin
        if (echo) begin
          width_cnt = 1;
          ph_cnt = 0;
          ph = PH_MEASURE;
        end else begin
          lim = (cfg_listen == 0) ? 1 : cfg_listen;
          ph_cnt++;
          if (ph_cnt >= lim) begin
            r.done    = 1'b1;
            r.status  = ST_NO_ECHO;
            last_dist = '0;
            ph_cnt = 0;
            ph = PH_IDLE;
          end
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          if (width_cnt < WIDTH_SAT) width_cnt++;
        end else begin
          prod = (64'(width_cnt) * 64'(cfg_scale)) >> FRAC_W;
          d = (prod > 64'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
          r.done    = 1'b1;
          last_dist = d;
          if (d >= cfg_min && d <= cfg_max) begin
            r.status = ST_IN_RANGE;
            bar_step = cfg_max / BAR_CELLS_DEF;
            if (bar_step == 0) bar_step = 1;
            cells = d / bar_step;
            r.bar = (cells >= BAR_CELLS_DEF) ? '0 : BAR_W'(BAR_CELLS_DEF - cells);
          end else begin
            r.status = ST_OUT_RANGE;
          end
          ph_cnt = 0;
          ph = PH_IDLE;
        end
      end
      default: begin
        ph = PH_IDLE;
        if (start) begin
          ph_cnt = 0;
          width_cnt = 0;
          ph = PH_TRIG;
        end
      end
    endcase
    r.busy = (ph != PH_IDLE);
    r.range_cm = last_dist;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_max    = MAX_DIST_RST;
      cfg_min    = MIN_DIST_RST;
      cfg_trig   = TRIG_RST;
      cfg_blank  = BLANK_RST;
      cfg_listen = LISTEN_RST;
      cfg_scale  = SCALE_RST;
      ph         = PH_IDLE;
      ph_cnt     = 0;
      width_cnt  = 0;
      last_dist  = '0;
      expected_ticks.delete();
      tick_depth = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{pin_drive_enable_i, pin_drive_level_i, busy_res_i, done_res_i,
                status_e'(status_i), range_cm_i, bar_cells_i};
        if (expected_ticks.size() == 0) begin
          $error("result transaction with no tick outstanding");
          mismatch_cnt++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("pin_drive_enable", want.drive_en, got.drive_en);
          check_field("pin_drive_level", want.drive_lvl, got.drive_lvl);
          check_field("busy_res", want.busy, got.busy);
          check_field("done_res", want.done, got.done);
          check_field("status", want.status, got.status);
          check_field("range_cm", want.range_cm, got.range_cm);
          check_field("bar_cells", want.bar, got.bar);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[PADDR_W-1:2]))
          REG_MAX_DIST: cfg_max    = pwdata_i[MAXD_W-1:0];
          REG_MIN_DIST: cfg_min    = pwdata_i[MAXD_W-1:0];
          REG_TRIG:     cfg_trig   = pwdata_i[TRIG_W-1:0];
          REG_BLANK:    cfg_blank  = pwdata_i[PCNT_W-1:0];
          REG_LISTEN:   cfg_listen = pwdata_i[PCNT_W-1:0];
          REG_SCALE:    cfg_scale  = pwdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        step_ranger(start_req_i, echo_level_i, want);
        expected_ticks.push_back(want);
      end
      tick_depth = expected_ticks.size();
    end
  end

  initial mismatch_cnt = 0;

endmodule

>>> tb/sv/ultrasonic_range_controller_test.sv
`timescale 1ns / 1ps

module ultrasonic_range_controller_test;
  import urc_pkg::*;

  typedef struct {
    int unsigned max_cm;
    int unsigned min_cm;
    int unsigned trig;
    int unsigned blank;
    int unsigned listen;
    int unsigned scale;
  } ranger_cfg_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [PADDR_W-1:0]  paddr        = '0;
  logic [PDATA_W-1:0]  pwdata       = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic                start_req_i  = 1'b0;
  logic                echo_level_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic                pin_drive_enable_o;
  logic                pin_drive_level_o;
  logic                busy_res_o;
  logic                done_res_o;
  logic [STATUS_W-1:0] status_o;
  logic [DIST_W-1:0]   range_cm_o;
  logic [BAR_W-1:0]    bar_cells_o;

  int unsigned pending_cnt;
  int unsigned mismatch_cnt;

  ranger_cfg_t cfg;
  int unsigned sent_items = 0;
  int unsigned burst_left = 0;
  bit          gaps_on    = 1'b1;
  bit          rx_always  = 1'b0;
  int          hold_seq   = 0;

  ultrasonic_range_controller dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .start_req_i        (start_req_i),
    .echo_level_i       (echo_level_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pin_drive_enable_o (pin_drive_enable_o),
    .pin_drive_level_o  (pin_drive_level_o),
    .busy_res_o         (busy_res_o),
    .done_res_o         (done_res_o),
    .status_o           (status_o),
    .range_cm_o         (range_cm_o),
    .bar_cells_o        (bar_cells_o)
  );

  urc_tick_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel_i             (psel),
    .penable_i          (penable),
    .pwrite_i           (pwrite),
    .pready_i           (pready),
    .paddr_i            (paddr),
    .pwdata_i           (pwdata),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .start_req_i        (start_req_i),
    .echo_level_i       (echo_level_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pin_drive_enable_i (pin_drive_enable_o),
    .pin_drive_level_i  (pin_drive_level_o),
    .busy_res_i         (busy_res_o),
    .done_res_i         (done_res_o),
    .status_i           (status_o),
    .range_cm_i         (range_cm_o),
    .bar_cells_i        (bar_cells_o),
    .pending_o          (pending_cnt),
    .mismatches_o       (mismatch_cnt)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("ultrasonic_range_controller_test: FAIL");
    $finish;
  end

  // result side: random stall stretches, plus a long hold-off on request
  initial begin
    int hold_left, stretch, mode_sel, seen_hold;
    hold_left = 0;
    stretch   = 0;
    mode_sel  = 0;
    seen_hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_always) begin
        out_ready_i <= 1'b1;
      end else begin
        if (stretch == 0) begin
          mode_sel = $urandom_range(0, 2);
          stretch  = $urandom_range(4, 64);
        end
        stretch--;
        case (mode_sel)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_tick(input logic start, input logic echo);
    in_valid_i   <= 1'b1;
    start_req_i  <= start;
    echo_level_i <= echo;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_cnt == 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic set_ranger(input ranger_cfg_t c);
    drain_results();
    write_reg(REG_MAX_DIST, c.max_cm);
    write_reg(REG_MIN_DIST, c.min_cm);
    write_reg(REG_TRIG, c.trig);
    write_reg(REG_BLANK, c.blank);
    write_reg(REG_LISTEN, c.listen);
    write_reg(REG_SCALE, c.scale);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg = c;
  endtask

  // one ping: start, trigger, blanking, then either a timeout or an echo
  task automatic measure(input int unsigned wait_n, input int unsigned width_n);
    int unsigned trig_n, listen_n;
    trig_n   = (cfg.trig == 0) ? 1 : cfg.trig;
    listen_n = (cfg.listen == 0) ? 1 : cfg.listen;
    send_tick(1'b1, rnd_bit());
    repeat (trig_n) send_tick(rnd_bit(), rnd_bit());
    repeat (cfg.blank) send_tick(rnd_bit(), rnd_bit());
    if (wait_n >= listen_n) begin
      repeat (listen_n) send_tick(rnd_bit(), 1'b0);
    end else begin
      repeat (wait_n) send_tick(rnd_bit(), 1'b0);
      repeat (width_n) send_tick(rnd_bit(), 1'b1);
      send_tick(rnd_bit(), 1'b0);
    end
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned stop, pick, listen_n, wait_n, width_n, tgt_cm;
    stop = sent_items + budget;
    while (sent_items < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) send_tick(1'b0, rnd_bit());
      end else if (pick < 14) begin
        send_tick(1'b1, rnd_bit());
        repeat ($urandom_range(1, 12)) send_tick(rnd_bit(), rnd_bit());
      end else begin
        listen_n = (cfg.listen == 0) ? 1 : cfg.listen;
        wait_n = ($urandom_range(0, 6) == 0) ? listen_n : $urandom_range(0, listen_n - 1);
        tgt_cm = $urandom_range(0, cfg.max_cm + cfg.max_cm / 4 + 2);
        width_n = ((tgt_cm << 16) + cfg.scale - 1) / cfg.scale + $urandom_range(0, 1);
        if (width_n == 0 || width_n > 300) width_n = $urandom_range(1, 300);
        measure(wait_n, width_n);
      end
    end
  endtask

  initial begin
    cfg = '{MAX_DIST_RST, MIN_DIST_RST, TRIG_RST, BLANK_RST, LISTEN_RST, SCALE_RST};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset, reconfigured while still blanking
    send_tick(1'b1, 1'b0);
    repeat (43) send_tick(rnd_bit(), rnd_bit());

    set_ranger('{1023, 0, 1, 0, 3, 65535});
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    repeat (3) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);

    // zero trigger and listen lengths, unit scale, min above max
    set_ranger('{20, 1023, 0, 1, 0, 1});
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // longest trigger, back-to-back ticks
    gaps_on = 1'b0;
    rx_always <= 1'b1;
    set_ranger('{1023, 0, 255, 30, 65535, 65535});
    measure(4, 40);
    drain_results();
    gaps_on = 1'b1;
    rx_always <= 1'b0;

    set_ranger('{20, 0, 1, 0, 1, 65535});
    run_random(130);
    set_ranger('{60, 10, 2, 5, 8, 40000});
    run_random(80);
    drain_results();
    run_random(60);
    set_ranger('{1023, 0, 3, 3, 10, 65535});
    run_random(30);
    hold_seq <= hold_seq + 1;
    run_random(80);
    set_ranger('{7, 3, 0, 2, 0, 32768});
    run_random(120);
    set_ranger('{300, 150, 4, 10, 20, 65535});
    run_random(60);
    set_ranger('{40, 0, 2, 1, 6, 1});
    run_random(60);

    drain_results();
    repeat (60) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ultrasonic_range_controller_test: PASS");
    end else begin
      $display("ultrasonic_range_controller_test: FAIL");
    end
    $finish;
  end

endmodule
